@@ src/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg: text console character engine package
// Geometry, field widths, character codes, shared structs and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Cursor widths: column may sit at COLUMNS (deferred wrap), row at ROWS
  localparam int COL_W     = $clog2(COLUMNS + 1);
  localparam int ROW_W     = $clog2(ROWS + 1);
  localparam int COL_EXT_W = $clog2(COLUMNS + 5);
  localparam int ROW_EXT_W = $clog2(ROWS + 2);
  localparam int POS_W     = $clog2(COLUMNS * (ROWS + 1) + 1);

  // Stream field widths
  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int CADDR_W    = 11;
  localparam int CURPOS_W   = 12;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (CURPOS_W + 1 + CADDR_W + CELL_W + 1);

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'b1;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam int                TAB_STEP     = 4;

  // Decoded command, latched at the input transfer
  typedef struct packed {
    logic                wr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CHAR_W-1:0]   wr_byte;
    logic                rd;
    logic                rd_ok;
    logic [ADDR_W-1:0]   rd_addr;
    logic                sweep;
    logic                scroll;
    logic                scrolled;
    logic [CURPOS_W-1:0] cursor_pos;
  } plan_t;

  // Memory request from the sweep engine
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] bg,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [CHAR_W-1:0]  ch);
    return {bg, fg, ch};
  endfunction

endpackage

`default_nettype wire

@@ src/tcce_ram.sv @@
// ----------------------------------------------------------------------------
// tcce_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/tcce_plan.sv @@
// ----------------------------------------------------------------------------
// tcce_plan: cursor registers and command decode
// Works out the cursor move, the cell write and any sweep for one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcce_plan import tcce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               commit,
  input  logic [KIND_W-1:0]  kind,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [CADDR_W-1:0] cell_address,
  output plan_t              plan
);

  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic [COL_EXT_W-1:0] col_x, col_next, wcol;
  logic [ROW_EXT_W-1:0] row_x, row_next, wrow;
  logic [POS_W-1:0]     pos;

  always_comb begin
    col_x    = COL_EXT_W'(col);
    row_x    = ROW_EXT_W'(row);
    col_next = col_x;
    row_next = row_x;
    wcol     = col_x;
    wrow     = row_x;
    plan          = '0;
    plan.wr_byte  = char_code;
    plan.rd_addr  = ADDR_W'(cell_address);
    plan.rd_ok    = 32'(cell_address) < CELL_COUNT;

    unique case (kind)
      KIND_WRITE: begin
        unique case (char_code)
          CH_NEWLINE: begin
            col_next = '0;
            row_next = row_x + 1'b1;
            if (row_next >= ROW_EXT_W'(ROWS)) begin
              plan.sweep    = 1'b1;
              plan.scroll   = 1'b1;
              plan.scrolled = 1'b1;
              row_next      = ROW_EXT_W'(ROWS - 1);
            end
          end
          CH_TAB: begin
            col_next = col_x + COL_EXT_W'(TAB_STEP);
            if (col_next >= COL_EXT_W'(COLUMNS)) begin
              col_next = '0;
              if (row_x < ROW_EXT_W'(ROWS)) begin
                row_next = row_x + 1'b1;
              end
            end
          end
          CH_RETURN: begin
            col_next = '0;
          end
          CH_BACKSPACE: begin
            if (col_x != '0) begin
              col_next = col_x - 1'b1;
              wcol     = col_next;
              // pending row below the screen: move only
              if (row_x < ROW_EXT_W'(ROWS)) begin
                plan.wr      = 1'b1;
                plan.wr_byte = CH_SPACE;
              end
            end
          end
          CH_BELL: begin
          end
          default: begin
            // deferred wrap, then scroll if past the bottom
            if (col_x >= COL_EXT_W'(COLUMNS)) begin
              wcol = '0;
              wrow = row_x + 1'b1;
            end
            if (wrow >= ROW_EXT_W'(ROWS)) begin
              plan.sweep    = 1'b1;
              plan.scroll   = 1'b1;
              plan.scrolled = 1'b1;
              wcol          = '0;
              wrow          = ROW_EXT_W'(ROWS - 1);
            end
            plan.wr  = 1'b1;
            col_next = wcol + 1'b1;
            row_next = wrow;
          end
        endcase
      end
      KIND_READ: begin
        plan.rd = 1'b1;
      end
      KIND_CLEAR: begin
        plan.sweep    = 1'b1;
        plan.scrolled = 1'b1;
        col_next      = '0;
        row_next      = '0;
      end
      default: begin
      end
    endcase

    plan.wr_addr    = ADDR_W'(wcol) + ADDR_W'(wrow) * ADDR_W'(COLUMNS);
    pos             = POS_W'(col_next) + POS_W'(row_next) * POS_W'(COLUMNS);
    plan.cursor_pos = CURPOS_W'(pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (commit) begin
      col <= COL_W'(col_next);
      row <= ROW_W'(row_next);
    end
  end

endmodule

`default_nettype wire

@@ src/tcce_sweep.sv @@
// ----------------------------------------------------------------------------
// tcce_sweep: whole-screen sweep engine
// Fills the store, or copies it up one row and blanks the bottom row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcce_sweep import tcce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              scroll,
  input  logic [CELL_W-1:0] fill,
  input  logic [CELL_W-1:0] rdata,
  output mem_req_t          req,
  output sweep_stat_t       stat
);

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY = ADDR_W'(COPY_COUNT);

  logic              run;
  logic              wv;
  logic              mode_scroll;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] widx;
  logic [CELL_W-1:0] fill_q;
  logic [ADDR_W:0]   rsum;

  // read one row ahead, write in the cycle after the read
  assign rsum      = {1'b0, cnt} + (ADDR_W + 1)'(COLUMNS);
  assign req.raddr = rsum[ADDR_W-1:0];
  assign req.we    = wv;
  assign req.waddr = widx;
  assign req.wdata = (mode_scroll && (widx < COPY)) ? rdata : fill_q;
  assign stat.busy = run | wv;
  assign stat.done = wv && (widx == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      // power-up pass writes zeros
      run         <= 1'b1;
      wv          <= 1'b0;
      mode_scroll <= 1'b0;
      fill_q      <= '0;
      cnt         <= '0;
    end else begin
      if (start) begin
        run         <= 1'b1;
        cnt         <= '0;
        mode_scroll <= scroll;
        fill_q      <= fill;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          run <= 1'b0;
        end
      end
      wv <= run;
    end
  end

  always_ff @(posedge clk) begin
    widx <= cnt;
  end

endmodule

`default_nettype wire

@@ src/text_console_char_engine.sv @@
// ----------------------------------------------------------------------------
// text_console_char_engine: character-cell text console engine
// Cell store with cursor, control characters, line wrap, scroll and clear.
// ----------------------------------------------------------------------------
// Timing: a command passes from the input transfer to the decode register,
//   then to the output register once the output is free; scroll and clear
//   first sweep the cell RAM, one cell per cycle on its single write port.
// Flow: one command at a time, sweep included; the next one is
//   taken once the result is in the output register.
// Reset: synchronous; zero-fill pass over the cell RAM with s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_engine import tcce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code[7:0], cell_address[18:8]
  input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // cursor_position[11:0], wrote_cell[12],
                                           // written_address[23:13],
                                           // cell_data[39:24], scrolled[40]
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COLOR_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  plan_t       plan_now;
  plan_t       plan_q;
  mem_req_t    sweep_req;
  sweep_stat_t sweep_stat;

  logic              accept;
  logic              out_free;
  logic              finish_go;
  logic [CELL_W-1:0] blank;
  logic [CELL_W-1:0] cell_wr;
  logic [CELL_W-1:0] rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0]  res_data;
  logic [CADDR_W-1:0] res_waddr;

  // Input side: only taken when idle, one command at a time
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Output register frees up in the same cycle it is taken
  assign out_free  = !m_tvalid || m_tready;
  assign finish_go = (state == ST_FINISH) && out_free;

  assign blank   = make_cell(bg_color, fg_color, CH_SPACE);
  assign cell_wr = make_cell(bg_color, fg_color, plan_q.wr_byte);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= COLOR_W'(7);
      bg_color <= COLOR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOREGROUND: fg_color <= cfg_data;
        CFG_BACKGROUND: bg_color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Cursor and decode; cursor commits on the input transfer
  tcce_plan u_plan (
    .clk          (clk),
    .rst          (rst),
    .commit       (accept),
    .kind         (s_tuser),
    .char_code    (s_tdata[CHAR_W-1:0]),
    .cell_address (s_tdata[CHAR_W +: CADDR_W]),
    .plan         (plan_now)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_q <= plan_now;
    end
  end

  // Sweep for scroll, clear and the power-up zero fill
  tcce_sweep u_sweep (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && plan_now.sweep),
    .scroll (plan_now.scroll),
    .fill   (blank),
    .rdata  (rdata),
    .req    (sweep_req),
    .stat   (sweep_stat)
  );

  // RAM port steering. The single cell write comes after any sweep, so a
  // character that forced a scroll lands on the freshly blanked bottom row.
  // The read for a cell query is issued at the input transfer and its
  // address held, so the read data stays put while the result waits.
  assign ram_we    = sweep_req.we || (finish_go && plan_q.wr);
  assign ram_waddr = sweep_req.we ? sweep_req.waddr : plan_q.wr_addr;
  assign ram_wdata = sweep_req.we ? sweep_req.wdata : cell_wr;
  assign ram_raddr = sweep_stat.busy     ? sweep_req.raddr :
                     (state == ST_IDLE)  ? plan_now.rd_addr : plan_q.rd_addr;

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Control sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (sweep_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = plan_now.sweep ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (sweep_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Result assembly; out-of-range reads return zero
  always_comb begin
    res_data  = '0;
    res_waddr = '0;
    if (plan_q.wr) begin
      res_data  = cell_wr;
      res_waddr = CADDR_W'(plan_q.wr_addr);
    end else if (plan_q.rd && plan_q.rd_ok) begin
      res_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      m_tdata <= {OUT_PAD_W'(0), plan_q.scrolled, res_data, res_waddr,
                  plan_q.wr, plan_q.cursor_pos};
    end
  end

endmodule

`default_nettype wire

@@ src/tcce_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_checker: port-level checks for the console engine
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcce_checker import tcce_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // held result must not change under backpressure
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // one command at a time: no second transfer right after the first
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while previous one in flight");

  // written address is zero unless a cell was written
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[12] |-> (m_tdata[23:13] == '0))
    else $error("written address set without a cell write");

  // cursor stays on the screen or on the pending row below the last row
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[11:0]) <= CELL_COUNT + COLUMNS))
    else $error("cursor position out of range");

endmodule

bind text_console_char_engine tcce_checker u_tcce_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
